// ===== rtl/core/bounded_change_making_search_macros.svh =====
// ----------------------------------------------------------------------------
// Bounded change-making search: assertion macros
// Shared assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_CHANGE_MAKING_SEARCH_MACROS_SVH
`define BOUNDED_CHANGE_MAKING_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside of reset.
`define BCMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every rising edge, reset included.
`define BCMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`else

`define BCMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCMS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/bcms_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded change-making search package
// Field widths, request and result types, and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bcms_pkg;

  // Fixed field widths of the request and result channels.
  localparam int VALUE_BITS     = 16;
  localparam int STOCK_BITS     = 4;
  localparam int TARGET_BITS    = 23;
  localparam int INDEX_OUT_BITS = 3;
  localparam int COUNT_OUT_BITS = 4;

  // Default number of coin types that the cell row holds.
  localparam int MAX_TYPES_DEF  = 8;

  // One coin-type request.
  typedef struct packed {
    logic [VALUE_BITS-1:0]  coin_value;
    logic [STOCK_BITS-1:0]  coin_stock;
    logic [TARGET_BITS-1:0] target_amount;
    logic                   last_coin;
  } bcms_in_t;

  // One result per loaded coin type.
  typedef struct packed {
    logic [INDEX_OUT_BITS-1:0] coin_index;
    logic [COUNT_OUT_BITS-1:0] used_count;
    logic                      found;
    logic                      last_result;
  } bcms_out_t;

  // Control from the sequencer to one cell.
  typedef struct packed {
    logic load;    // store this request's type in the cell
    logic active;  // cell holds a type of the current batch
    logic start;   // preset the digit to full stock
    logic step;    // advance the down counter by one
    logic take;    // current combination is the new best
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bcms_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded change-making search: counter cell
// One digit of the mixed-radix down counter, with the sum and coin-total
// corrections that apply when this digit is the one that decrements.
// ----------------------------------------------------------------------------
`default_nettype none

module bcms_cell import bcms_pkg::*; #(
  parameter int SUM_BITS = 23,
  parameter int TOT_BITS = 7
) (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic [STOCK_BITS-1:0] load_stock,
  input  wire logic [SUM_BITS-1:0]   load_dsum,
  input  wire logic [TOT_BITS-1:0]   load_dtot,
  input  wire logic                  borrow_in,
  output logic                       borrow_out,
  input  wire logic [SUM_BITS-1:0]   dsum_in,
  output logic [SUM_BITS-1:0]        dsum_out,
  input  wire logic [TOT_BITS-1:0]   dtot_in,
  output logic [TOT_BITS-1:0]        dtot_out,
  output logic [STOCK_BITS-1:0]      best_count
);

  logic [STOCK_BITS-1:0] stock_r;
  logic [SUM_BITS-1:0]   dsum_r;
  logic [TOT_BITS-1:0]   dtot_r;
  logic [STOCK_BITS-1:0] count_r;
  logic [STOCK_BITS-1:0] count_nxt;
  logic [STOCK_BITS-1:0] best_r;
  logic [STOCK_BITS-1:0] eff_stock;
  logic                  nonzero;
  logic                  dec;

  // A cell outside the batch behaves as a digit with no stock.
  assign eff_stock = ctrl.active ? stock_r : '0;
  assign nonzero   = (count_r != '0);

  // This digit decrements when all lower digits sit at zero.
  assign dec        = borrow_in && nonzero;
  assign borrow_out = borrow_in && !nonzero;

  // At most one cell drives its correction onto the chain.
  assign dsum_out = dsum_in | (dec ? dsum_r : '0);
  assign dtot_out = dtot_in | (dec ? dtot_r : '0);

  // Next digit value: preset, decrement, or wrap back to stock.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.start) begin
      count_nxt = eff_stock;
    end else if (ctrl.step && borrow_in) begin
      count_nxt = nonzero ? (count_r - STOCK_BITS'(1)) : eff_stock;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      stock_r <= load_stock;
      dsum_r  <= load_dsum;
      dtot_r  <= load_dtot;
    end
    count_r <= count_nxt;
    if (ctrl.take) begin
      best_r <= count_r;
    end
  end

  assign best_count = best_r;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_change_making_search.sv =====
// ----------------------------------------------------------------------------
// Bounded change-making search
// Exhaustive search for the fewest coins that pay a target exactly.
// ----------------------------------------------------------------------------
// Coin types arrive one request per cycle (value and stock) while loading;
// the request with last_coin set also carries the target and starts the
// search. After the preset state S_START the block visits one combination
// of coin counts per cycle, so it covers a number of combinations equal
// to the product of (stock + 1) over the loaded types. The cell row steps
// the mixed-radix down counter once per cycle while the running value sum
// and coin total are corrected by a single add each. Combinations are visited
// from full stock downward with type 0 as the fastest digit, and the first
// one with the strictly smallest coin total wins. One result per loaded type
// then leaves through an output register, one per cycle when not stalled;
// new requests are taken while the last result is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_change_making_search_macros.svh"

module bounded_change_making_search import bcms_pkg::*; #(
  parameter int MAX_TYPES = MAX_TYPES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire bcms_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output bcms_out_t      out_data
);

  localparam int IDX_BITS  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int CNT_BITS  = $clog2(MAX_TYPES + 1);
  localparam int SUM_BITS  = VALUE_BITS + STOCK_BITS + $clog2(MAX_TYPES);
  localparam int TOT_BITS  = STOCK_BITS + $clog2(MAX_TYPES);
  localparam int PROD_BITS = VALUE_BITS + STOCK_BITS;
  localparam int CMP_BITS  = (SUM_BITS > TARGET_BITS) ? SUM_BITS : TARGET_BITS;

  typedef enum logic [1:0] {
    S_LOAD,
    S_START,
    S_SEARCH,
    S_EMIT
  } state_t;

  state_t                 state_r;
  logic [CNT_BITS-1:0]    loaded_r;
  logic [SUM_BITS-1:0]    run_sum_r;
  logic [TOT_BITS-1:0]    run_tot_r;
  logic [TARGET_BITS-1:0] target_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic [TOT_BITS-1:0]    tot_r;
  logic [TOT_BITS-1:0]    best_tot_r;
  logic                   found_r;
  logic [IDX_BITS-1:0]    e_r;
  logic                   out_valid_r;
  bcms_out_t              out_data_r;

  logic                   in_acc;
  logic                   room;
  logic                   load_now;
  logic [PROD_BITS-1:0]   prod;
  logic [SUM_BITS-1:0]    load_dsum;
  logic [TOT_BITS-1:0]    load_dtot;
  logic                   hit;
  logic                   done;
  logic                   emit_ok;
  logic                   emit_last;
  logic [STOCK_BITS-1:0]  best_sel;

  cell_ctrl_t             ctrl [MAX_TYPES];
  logic [STOCK_BITS-1:0]  best_count [MAX_TYPES];
  logic                   borrow [MAX_TYPES+1];
  logic [SUM_BITS-1:0]    dsum_chain [MAX_TYPES+1];
  logic [TOT_BITS-1:0]    dtot_chain [MAX_TYPES+1];

  // Request handshake: types are taken only while loading.
  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign room     = (loaded_r < CNT_BITS'(MAX_TYPES));
  assign load_now = in_acc && room;

  // Running full-stock sum and the per-cell corrections stored at load time.
  assign prod      = PROD_BITS'(in_data.coin_value) * PROD_BITS'(in_data.coin_stock);
  assign load_dsum = run_sum_r - SUM_BITS'(in_data.coin_value);
  assign load_dtot = run_tot_r - TOT_BITS'(1);

  // Chain heads: the lowest digit always sees a borrow.
  assign borrow[0]     = 1'b1;
  assign dsum_chain[0] = '0;
  assign dtot_chain[0] = '0;

  // Row of counter cells.
  for (genvar g = 0; g < MAX_TYPES; g++) begin : g_cell
    assign ctrl[g].load   = load_now && (loaded_r[IDX_BITS-1:0] == IDX_BITS'(g));
    assign ctrl[g].active = (CNT_BITS'(g) < loaded_r);
    assign ctrl[g].start  = (state_r == S_START);
    assign ctrl[g].step   = (state_r == S_SEARCH);
    assign ctrl[g].take   = hit;

    bcms_cell #(
      .SUM_BITS (SUM_BITS),
      .TOT_BITS (TOT_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .load_stock (in_data.coin_stock),
      .load_dsum  (load_dsum),
      .load_dtot  (load_dtot),
      .borrow_in  (borrow[g]),
      .borrow_out (borrow[g+1]),
      .dsum_in    (dsum_chain[g]),
      .dsum_out   (dsum_chain[g+1]),
      .dtot_in    (dtot_chain[g]),
      .dtot_out   (dtot_chain[g+1]),
      .best_count (best_count[g])
    );
  end

  // Current combination pays exactly and beats the best so far.
  assign hit = (state_r == S_SEARCH)
            && (CMP_BITS'(sum_r) == CMP_BITS'(target_r))
            && (!found_r || (tot_r < best_tot_r));

  // All digits at zero: this is the final combination.
  assign done = borrow[MAX_TYPES];

  // Result selection for the output register.
  assign emit_ok   = !out_valid_r || !out_stall;
  assign emit_last = ((CNT_BITS'(e_r) + CNT_BITS'(1)) == loaded_r);
  assign best_sel  = best_count[e_r];

  // Sequencer, running sums and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      loaded_r    <= '0;
      run_sum_r   <= '0;
      run_tot_r   <= '0;
      target_r    <= '0;
      sum_r       <= '0;
      tot_r       <= '0;
      best_tot_r  <= '1;
      found_r     <= 1'b0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result empties the output register unless the next one refills it.
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (load_now) begin
            run_sum_r <= run_sum_r + SUM_BITS'(prod);
            run_tot_r <= run_tot_r + TOT_BITS'(in_data.coin_stock);
            loaded_r  <= loaded_r + CNT_BITS'(1);
          end
          if (in_acc && in_data.last_coin) begin
            target_r <= in_data.target_amount;
            state_r  <= S_START;
          end
        end
        S_START: begin
          sum_r      <= run_sum_r;
          tot_r      <= run_tot_r;
          run_sum_r  <= '0;
          run_tot_r  <= '0;
          found_r    <= 1'b0;
          best_tot_r <= '1;
          state_r    <= S_SEARCH;
        end
        S_SEARCH: begin
          if (hit) begin
            found_r    <= 1'b1;
            best_tot_r <= tot_r;
          end
          if (done) begin
            e_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            sum_r <= sum_r + dsum_chain[MAX_TYPES];
            tot_r <= tot_r + dtot_chain[MAX_TYPES];
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_r            <= 1'b1;
            out_data_r.coin_index  <= INDEX_OUT_BITS'(e_r);
            out_data_r.used_count  <= found_r ? COUNT_OUT_BITS'(best_sel) : '0;
            out_data_r.found       <= found_r;
            out_data_r.last_result <= emit_last;
            if (emit_last) begin
              loaded_r <= '0;
              state_r  <= S_LOAD;
            end else begin
              e_r <= e_r + IDX_BITS'(1);
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A search always covers at least one loaded type.
  `BCMS_ASSERT(a_search_loaded, clk, rst_n, (state_r == S_SEARCH) |-> (loaded_r != '0), "search with no types loaded")

  // A winning combination is recorded with its coin total.
  `BCMS_ASSERT(a_hit_recorded, clk, rst_n, hit |=> (found_r && (best_tot_r == $past(tot_r))), "best total not recorded")

  // The result index stays inside the loaded batch.
  `BCMS_ASSERT(a_emit_range, clk, rst_n, (state_r == S_EMIT) |-> (CNT_BITS'(e_r) < loaded_r), "result index beyond batch")

  // Reset leaves no result pending and the block loading.
  `BCMS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> (!out_valid_r && (state_r == S_LOAD)), "result pending after reset")

endmodule

`default_nettype wire

// ===== dv/bounded_change_making_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded change-making search testbench
// Loads batches of coin types and predicts, for each batch, the coin counts
// that pay the target with the fewest coins. The predictor walks the same
// down-counter order as the block and keeps the first strictly better fit.
// Results are checked field by field, in order, under random gaps on both
// sides.
// ----------------------------------------------------------------------------
module testbench;
  import bcms_pkg::*;

  localparam int MAX_TYPES     = MAX_TYPES_DEF;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 50;
  localparam int RANDOM_ITEMS  = 456;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 60;
  localparam int NONE_TOTAL    = 127;

  // One request for the driver, optionally held back until the block drains.
  typedef struct {
    bcms_in_t req;
    bit       drain_first;
  } coin_item_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  bcms_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  bcms_out_t out_data;

  coin_item_t pending_coins[$];
  bcms_out_t  expected_change[$];

  // Shadow of the loaded coin types of the current batch.
  logic [VALUE_BITS-1:0] coin_values[MAX_TYPES];
  logic [STOCK_BITS-1:0] coin_stocks[MAX_TYPES];
  int                    types_loaded = 0;

  int failures     = 0;
  int results_seen = 0;
  int cycles       = 0;
  int gap_left     = 0;
  int calm_left    = 0;
  int stall_left   = 0;
  int free_left    = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  bounded_change_making_search i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Walk every combination from full stock downward, type 0 fastest, and keep
  // the first one that pays the target with a strictly smaller coin total.
  function automatic void predict_change(input logic [TARGET_BITS-1:0] target);
    logic [STOCK_BITS-1:0] digit[MAX_TYPES];
    logic [STOCK_BITS-1:0] best[MAX_TYPES];
    longint                combos;
    longint                sum;
    int                    total;
    int                    best_total;
    bit                    hit;
    bit                    carry;
    bcms_out_t             res;
    combos     = 1;
    best_total = NONE_TOTAL;
    hit        = 1'b0;
    for (int i = 0; i < MAX_TYPES; i++) begin
      best[i]  = '0;
      digit[i] = coin_stocks[i];
    end
    for (int i = 0; i < types_loaded; i++) begin
      combos = combos * (longint'(coin_stocks[i]) + 1);
    end
    for (longint k = 0; k < combos; k++) begin
      sum   = 0;
      total = 0;
      for (int i = 0; i < types_loaded; i++) begin
        sum   = sum + longint'(coin_values[i]) * longint'(digit[i]);
        total = total + int'(digit[i]);
      end
      if (sum == longint'(target) && total < best_total) begin
        hit        = 1'b1;
        best_total = total;
        best       = digit;
      end
      // Step the mixed-radix down counter; a digit that passes zero wraps.
      carry = 1'b1;
      for (int i = 0; i < types_loaded; i++) begin
        if (carry) begin
          if (digit[i] != 0) begin
            digit[i] = digit[i] - 1'b1;
            carry    = 1'b0;
          end else begin
            digit[i] = coin_stocks[i];
          end
        end
      end
    end
    for (int i = 0; i < types_loaded; i++) begin
      res.coin_index  = i[INDEX_OUT_BITS-1:0];
      res.used_count  = hit ? best[i] : '0;
      res.found       = hit;
      res.last_result = (i == types_loaded - 1);
      expected_change.push_back(res);
    end
  endfunction

  // Track one accepted request; the marked last one runs the search.
  function automatic void absorb_coin(input bcms_in_t req);
    if (types_loaded < MAX_TYPES) begin
      coin_values[types_loaded] = req.coin_value;
      coin_stocks[types_loaded] = req.coin_stock;
      types_loaded++;
    end
    if (req.last_coin) begin
      predict_change(req.target_amount);
      types_loaded = 0;
    end
  endfunction

  function automatic void queue_coin(input int unsigned value, input int unsigned stock,
                                     input int unsigned target, input bit last,
                                     input bit drain);
    coin_item_t item;
    item.req.coin_value    = value[VALUE_BITS-1:0];
    item.req.coin_stock    = stock[STOCK_BITS-1:0];
    item.req.target_amount = target[TARGET_BITS-1:0];
    item.req.last_coin     = last;
    item.drain_first       = drain;
    pending_coins.push_back(item);
  endfunction

  function automatic int unsigned any_target();
    return $urandom_range(0, (1 << TARGET_BITS) - 1);
  endfunction

  // One random batch; the stock product is capped to keep the search short.
  function automatic int random_batch(input bit drain);
    int unsigned vals[MAX_TYPES];
    int unsigned stocks[MAX_TYPES];
    int unsigned cap;
    int unsigned prod;
    int unsigned reach;
    int unsigned target;
    int unsigned pick;
    int          n;
    int          kind;
    n = $urandom_range(1, MAX_TYPES);
    if ($urandom_range(0, 11) == 0) n = $urandom_range(MAX_TYPES + 1, MAX_TYPES + 3);
    pick = $urandom_range(0, 99);
    cap  = (pick < 80) ? 300 : (pick < 97) ? 2000 : 6000;
    kind = $urandom_range(0, 99);
    prod = 1;
    reach = 0;
    for (int i = 0; i < n; i++) begin
      int unsigned v;
      int unsigned s;
      pick = $urandom_range(0, 99);
      if (pick < 5) v = 0;
      else if (kind < 45) v = $urandom_range(1, 12);
      else if (kind < 70) v = $urandom_range(1, 2000);
      else v = $urandom_range(0, (1 << VALUE_BITS) - 1);
      s = $urandom_range(0, (1 << STOCK_BITS) - 1);
      while (prod * (s + 1) > cap) s = s / 2;
      if (i < MAX_TYPES) begin
        prod      = prod * (s + 1);
        vals[i]   = v;
        stocks[i] = s;
        reach     = reach + v * $urandom_range(0, s);
      end
      if (i == n - 1) begin
        // Mostly reachable amounts, with some that are likely to miss.
        pick = $urandom_range(0, 99);
        if (pick < 55) target = reach;
        else if (pick < 70) target = $urandom_range(0, 200);
        else if (pick < 85) target = any_target();
        else target = reach + 1;
        queue_coin(v, s, target, 1'b1, drain && (i == 0));
      end else begin
        queue_coin(v, s, any_target(), 1'b0, drain && (i == 0));
      end
    end
    return n;
  endfunction

  // Gap after an accepted request: mostly none, a few long, and calm stretches.
  function automatic int pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = 40;
      return 0;
    end
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Request driver: presents queued items and tracks the accepted ones.
  always @(posedge clk) begin
    logic offering;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        absorb_coin(in_data);
        offering = 1'b0;
        gap_left = pick_gap();
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_coins.size() != 0 &&
                     !(pending_coins[0].drain_first && expected_change.size() != 0)) begin
          in_data  <= pending_coins[0].req;
          offering = 1'b1;
          pending_coins.pop_front();
        end
      end
      in_valid <= offering;
    end
  end

  // Long receiver hold-off, once, after some results have come through.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Random receiver stalls in runs of varying length.
  always @(posedge clk) begin
    int unsigned r;
    if (stall_left == 0 && free_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 50) free_left = $urandom_range(1, 8);
      else if (r < 85) stall_left = $urandom_range(1, 3);
      else if (r < 97) stall_left = $urandom_range(4, 12);
      else stall_left = $urandom_range(20, 50);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      free_left--;
      out_stall <= (hold_left != 0);
    end
  end

  // Result monitor: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    bcms_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_change.size() == 0) begin
        $error("unexpected result: coin_index %0d used_count %0d found %0d last_result %0d",
               out_data.coin_index, out_data.used_count, out_data.found,
               out_data.last_result);
        failures++;
      end else begin
        want = expected_change.pop_front();
        if (out_data.coin_index !== want.coin_index) begin
          $error("coin_index: expected %0d, actual %0d", want.coin_index, out_data.coin_index);
          failures++;
        end
        if (out_data.used_count !== want.used_count) begin
          $error("used_count: expected %0d, actual %0d", want.used_count, out_data.used_count);
          failures++;
        end
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_data.found);
          failures++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result: expected %0d, actual %0d", want.last_result,
                 out_data.last_result);
          failures++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bounded_change_making_search test failed");
      $finish;
    end
  end

  initial begin
    int queued;
    // Zero target with a single worthless coin, then a full single stock.
    queue_coin(0, 0, 0, 1'b1, 1'b0);
    queue_coin(16'hFFFF, 15, 65535 * 15, 1'b1, 1'b0);
    queue_coin(16'hFFFF, 15, (1 << TARGET_BITS) - 1, 1'b1, 1'b0);
    // Fewest coins among several ways to pay.
    queue_coin(1, 3, any_target(), 1'b0, 1'b0);
    queue_coin(2, 3, any_target(), 1'b0, 1'b0);
    queue_coin(5, 3, 7, 1'b1, 1'b0);
    // Two equal coins: the first fit in counter order must win the tie.
    queue_coin(3, 2, any_target(), 1'b0, 1'b0);
    queue_coin(3, 2, 3, 1'b1, 1'b0);
    // No combination pays an odd amount with even coins.
    queue_coin(4, 3, any_target(), 1'b0, 1'b0);
    queue_coin(6, 3, 5, 1'b1, 1'b0);
    // Store full: the coins beyond the eighth would pay in one coin if kept.
    for (int i = 0; i < MAX_TYPES; i++) queue_coin(1 << i, 1, any_target(), 1'b0, 1'b0);
    queue_coin(200, 1, any_target(), 1'b0, 1'b0);
    queue_coin(200, 1, 200, 1'b1, 1'b0);
    // Large stock product with many tied minimal answers.
    queue_coin(1, 15, any_target(), 1'b0, 1'b0);
    queue_coin(7, 15, any_target(), 1'b0, 1'b0);
    queue_coin(13, 15, any_target(), 1'b0, 1'b0);
    queue_coin(16'hFFFF, 15, 65535 + 13 * 3 + 7 * 2 + 5, 1'b1, 1'b0);

    // Random batches; now and then the sender waits for the block to drain.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      queued += random_batch(queued == 0 || $urandom_range(0, 29) == 0);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_coins.size() != 0 || in_valid) @(posedge clk);
    while (expected_change.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("bounded_change_making_search test passed");
    end else begin
      $display("bounded_change_making_search test failed");
    end
    $finish;
  end

endmodule
